// ===== rtl/bf_pkg.sv =====
package bf_pkg;

	localparam int unsigned ROUNDS        = 16;
	localparam int unsigned KEY_WORDS_MAX = 14;
	localparam int unsigned P_DEPTH       = 18;
	localparam int unsigned S_DEPTH       = 1024;
	localparam int unsigned BOX_SIZE      = 256;

	localparam int unsigned P_IDX_W   = $clog2(P_DEPTH);
	localparam int unsigned S_IDX_W   = $clog2(S_DEPTH);
	localparam int unsigned K_IDX_W   = $clog2(KEY_WORDS_MAX);
	localparam int unsigned RND_W     = $clog2(ROUNDS + 1);
	localparam int unsigned KCNT_W    = 4;
	localparam logic [KCNT_W-1:0] KCNT_RESET = 4'd8;

	typedef enum logic [2:0] {
		KIND_WRITE_P  = 3'd0,
		KIND_WRITE_S  = 3'd1,
		KIND_WRITE_K  = 3'd2,
		KIND_EXPAND   = 3'd3,
		KIND_ENCRYPT  = 3'd4,
		KIND_DECRYPT  = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XOR_RD,
		ST_XOR_WR,
		ST_RND_P,
		ST_RND_S,
		ST_RND_F,
		ST_WHITE,
		ST_STORE,
		ST_STORE_HI,
		ST_OUT
	} state_t;

	localparam logic [0:0] REG_KEY_WORD_COUNT = 1'd0;

endpackage

// ===== rtl/bf_sbox.sv =====
module bf_sbox (
	input  logic                          clk,
	input  logic                          we,
	input  logic [bf_pkg::S_IDX_W-1:0]    waddr,
	input  logic [31:0]                   wdata,
	input  logic [31:0]                   x,
	output logic [31:0]                   f
);

	logic [31:0] box0 [bf_pkg::BOX_SIZE];
	logic [31:0] box1 [bf_pkg::BOX_SIZE];
	logic [31:0] box2 [bf_pkg::BOX_SIZE];
	logic [31:0] box3 [bf_pkg::BOX_SIZE];
	logic [31:0] a_q, b_q, c_q, d_q;

	always_ff @(posedge clk) begin
		if (we) begin
			case (waddr[9:8])
				2'd0: box0[waddr[7:0]] <= wdata;
				2'd1: box1[waddr[7:0]] <= wdata;
				2'd2: box2[waddr[7:0]] <= wdata;
				default: box3[waddr[7:0]] <= wdata;
			endcase
		end
		a_q <= box0[x[31:24]];
		b_q <= box1[x[23:16]];
		c_q <= box2[x[15:8]];
		d_q <= box3[x[7:0]];
	end

	assign f = ((a_q + b_q) ^ c_q) + d_q;

endmodule

// ===== rtl/blowfish_block_cipher.sv =====
// Channel | Direction | Signals
// in      | input     | in_valid, in_ready, kind, index, word, block_in
// out     | output    | out_valid, out_ready, block_out
// cfg     | input     | psel, penable, pwrite, paddr, pwdata, prdata, pready
// One shared round unit runs each round as a P read, an S-box read and an F add.
// An encrypt or decrypt beat runs all ROUNDS rounds and a whitening step; writes go straight to output.
// Key expansion XORs the key into all 18 P entries, then runs 521 block encryptions.
// Reset clears control state and sets key_word_count to 8; tables are unset.
// A beat is accepted only when idle; a held result stalls the next beat.
module blowfish_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [9:0]  index,
	input  logic [31:0] word,
	input  logic [63:0] block_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] block_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	bf_pkg::state_t state_q, state_d;

	logic [31:0] p_mem [bf_pkg::P_DEPTH];
	logic [31:0] k_mem [bf_pkg::KEY_WORDS_MAX];

	logic [bf_pkg::KCNT_W-1:0]  kcnt_q;
	logic [31:0]                l_q, r_q, p_rd_q;
	logic [63:0]                res_q;
	logic                       dec_q, exp_q;
	logic [bf_pkg::RND_W-1:0]   rnd_q;
	logic [bf_pkg::P_IDX_W-1:0] pi_q;
	logic [bf_pkg::K_IDX_W-1:0] ki_q;
	logic [bf_pkg::S_IDX_W-1:0] si_q;
	logic                       in_p_q;
	logic [31:0]                f_val;
	logic [31:0]                l_mix;
	logic                       s_we;
	logic [bf_pkg::S_IDX_W-1:0] s_waddr;
	logic [31:0]                s_wdata;
	logic [bf_pkg::KCNT_W-1:0]  kn;
	logic                       acc;
	logic [bf_pkg::P_IDX_W-1:0] rd_idx;

	assign pready = 1'b1;
	assign prdata = {28'd0, kcnt_q};
	assign in_ready = (state_q == bf_pkg::ST_IDLE) && !out_valid;
	assign acc = in_valid && in_ready;
	assign block_out = res_q;
	assign l_mix = l_q ^ p_rd_q;

	assign kn = (kcnt_q == '0) ? bf_pkg::KCNT_W'(1) :
		(kcnt_q > bf_pkg::KCNT_W'(bf_pkg::KEY_WORDS_MAX)) ?
		bf_pkg::KCNT_W'(bf_pkg::KEY_WORDS_MAX) : kcnt_q;

	always_comb begin
		rd_idx = dec_q ? bf_pkg::P_IDX_W'(bf_pkg::ROUNDS + 1 - 32'(rnd_q))
			: bf_pkg::P_IDX_W'(rnd_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kcnt_q <= bf_pkg::KCNT_RESET;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == bf_pkg::REG_KEY_WORD_COUNT && paddr[1:0] == 2'd0) begin
			kcnt_q <= pwdata[bf_pkg::KCNT_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bf_pkg::ST_IDLE: begin
				if (acc) begin
					case (kind)
						bf_pkg::KIND_EXPAND: state_d = bf_pkg::ST_XOR_RD;
						bf_pkg::KIND_ENCRYPT, bf_pkg::KIND_DECRYPT:
							state_d = bf_pkg::ST_RND_P;
						default: state_d = bf_pkg::ST_OUT;
					endcase
				end
			end
			bf_pkg::ST_XOR_RD: state_d = bf_pkg::ST_XOR_WR;
			bf_pkg::ST_XOR_WR: state_d = (pi_q == bf_pkg::P_IDX_W'(bf_pkg::P_DEPTH - 1))
				? bf_pkg::ST_RND_P : bf_pkg::ST_XOR_RD;
			bf_pkg::ST_RND_P: state_d = (rnd_q == bf_pkg::RND_W'(bf_pkg::ROUNDS))
				? bf_pkg::ST_WHITE : bf_pkg::ST_RND_S;
			bf_pkg::ST_RND_S: state_d = bf_pkg::ST_RND_F;
			bf_pkg::ST_RND_F: state_d = bf_pkg::ST_RND_P;
			bf_pkg::ST_WHITE: state_d = exp_q ? bf_pkg::ST_STORE : bf_pkg::ST_OUT;
			bf_pkg::ST_STORE: state_d = in_p_q ? bf_pkg::ST_RND_P : bf_pkg::ST_STORE_HI;
			bf_pkg::ST_STORE_HI: state_d = (si_q == bf_pkg::S_IDX_W'(bf_pkg::S_DEPTH - 2))
				? bf_pkg::ST_OUT : bf_pkg::ST_RND_P;
			bf_pkg::ST_OUT: state_d = bf_pkg::ST_IDLE;
			default: state_d = bf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_we = 1'b0;
		s_waddr = index;
		s_wdata = word;
		case (state_q)
			bf_pkg::ST_IDLE: s_we = acc && kind == bf_pkg::KIND_WRITE_S;
			bf_pkg::ST_STORE: begin
				s_we = !in_p_q;
				s_waddr = si_q;
				s_wdata = l_q;
			end
			bf_pkg::ST_STORE_HI: begin
				s_we = 1'b1;
				s_waddr = si_q + bf_pkg::S_IDX_W'(1);
				s_wdata = r_q;
			end
			default: s_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bf_pkg::ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bf_pkg::ST_OUT) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	bf_sbox u_sbox (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.x     (l_mix),
		.f     (f_val)
	);

	always_ff @(posedge clk) begin
		p_rd_q <= p_mem[rd_idx];
		case (state_q)
			bf_pkg::ST_IDLE: begin
				if (acc) begin
					dec_q <= kind == bf_pkg::KIND_DECRYPT;
					exp_q <= kind == bf_pkg::KIND_EXPAND;
					rnd_q <= '0;
					pi_q <= '0;
					ki_q <= '0;
					si_q <= '0;
					in_p_q <= 1'b1;
					res_q <= '0;
					if (kind == bf_pkg::KIND_EXPAND) begin
						l_q <= '0;
						r_q <= '0;
					end else begin
						l_q <= block_in[63:32];
						r_q <= block_in[31:0];
					end
					if (kind == bf_pkg::KIND_WRITE_P && index < 10'(bf_pkg::P_DEPTH))
						p_mem[index[bf_pkg::P_IDX_W-1:0]] <= word;
					if (kind == bf_pkg::KIND_WRITE_K && index < 10'(bf_pkg::KEY_WORDS_MAX))
						k_mem[index[bf_pkg::K_IDX_W-1:0]] <= word;
				end
			end
			bf_pkg::ST_XOR_RD: ;
			bf_pkg::ST_XOR_WR: begin
				p_mem[pi_q] <= p_mem[pi_q] ^ k_mem[ki_q];
				pi_q <= (pi_q == bf_pkg::P_IDX_W'(bf_pkg::P_DEPTH - 1)) ? '0
					: pi_q + bf_pkg::P_IDX_W'(1);
				ki_q <= (32'(ki_q) + 1 >= 32'(kn)) ? '0 : ki_q + bf_pkg::K_IDX_W'(1);
			end
			bf_pkg::ST_RND_S: l_q <= l_mix;
			bf_pkg::ST_RND_F: begin
				l_q <= r_q ^ f_val;
				r_q <= l_q;
				rnd_q <= rnd_q + bf_pkg::RND_W'(1);
			end
			bf_pkg::ST_WHITE: begin
				if (dec_q) begin
					l_q <= r_q ^ p_mem[0];
					r_q <= l_q ^ p_mem[1];
				end else begin
					l_q <= r_q ^ p_mem[bf_pkg::ROUNDS % bf_pkg::P_DEPTH + 1];
					r_q <= l_q ^ p_mem[bf_pkg::ROUNDS % bf_pkg::P_DEPTH];
				end
				res_q <= exp_q ? 64'd0 : (dec_q ? {r_q ^ p_mem[0], l_q ^ p_mem[1]}
					: {r_q ^ p_mem[bf_pkg::ROUNDS + 1], l_q ^ p_mem[bf_pkg::ROUNDS]});
			end
			bf_pkg::ST_STORE: begin
				rnd_q <= '0;
				if (in_p_q) begin
					p_mem[pi_q] <= l_q;
					p_mem[pi_q + bf_pkg::P_IDX_W'(1)] <= r_q;
					if (pi_q == bf_pkg::P_IDX_W'(bf_pkg::P_DEPTH - 2)) in_p_q <= 1'b0;
					else pi_q <= pi_q + bf_pkg::P_IDX_W'(2);
				end
			end
			bf_pkg::ST_STORE_HI: si_q <= si_q + bf_pkg::S_IDX_W'(2);
			default: ;
		endcase
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(block_out));
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != bf_pkg::ST_IDLE |-> !in_ready);
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bf_pkg::ST_OUT |=> out_valid);

endmodule
